// File: rtl/core/upq_pkg.sv
`default_nettype none

package upq_pkg;

	localparam logic [1:0] OP_FEED  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [1:0] RG_FILE  = 2'd0;
	localparam logic [1:0] RG_NAME  = 2'd1;
	localparam logic [1:0] RG_VALUE = 2'd2;

	localparam logic [1:0] PH_PREFIX = 2'd0;
	localparam logic [1:0] PH_FILE   = 2'd1;
	localparam logic [1:0] PH_NAME   = 2'd2;
	localparam logic [1:0] PH_VALUE  = 2'd3;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_FIN   = 3'd1;
	localparam logic [2:0] ST_BAD   = 3'd2;
	localparam logic [2:0] ST_OVF   = 3'd3;
	localparam logic [2:0] ST_WRONG = 3'd4;

	localparam logic [7:0] CH_LOW   = 8'h20;
	localparam logic [7:0] CH_HIGH  = 8'h7e;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUEST = 8'h3f;
	localparam logic [7:0] CH_EQ    = 8'h3d;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_DASH  = 8'h2d;
	localparam logic [7:0] CH_UNDER = 8'h5f;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_NUL   = 8'h00;

	localparam int PREFIX_LEN = 5;

	typedef struct packed {
		logic       wr_en;
		logic [1:0] wr_region;
		logic       rd_en;
		logic       rd_ok;
		logic [1:0] rd_region;
	} store_cmd_t;

	function automatic logic [7:0] prefix_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h47;
			3'd1: c = 8'h45;
			3'd2: c = 8'h54;
			3'd3: c = 8'h20;
			3'd4: c = 8'h2f;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic is_alnum_dot(input logic [7:0] c);
		return (c inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a], CH_DOT});
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/upq_store.sv
`default_nettype none

module upq_store #(
	parameter int FIELD_LEN = 16,
	parameter int MAX_PAIRS = 10,
	localparam int SLOT = FIELD_LEN + 1,
	localparam int DEPTH = MAX_PAIRS * SLOT,
	localparam int FW = $clog2(SLOT),
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire upq_pkg::store_cmd_t cmd,
	input  wire logic [FW-1:0]      fn_wr_idx,
	input  wire logic [AW-1:0]      pair_wr_addr,
	input  wire logic [7:0]         wr_data,
	input  wire logic [FW-1:0]      fn_rd_idx,
	input  wire logic [AW-1:0]      pair_rd_addr,
	output logic [7:0]              rd_data
);

	logic [7:0] fn_mem    [SLOT];
	logic [7:0] name_mem  [DEPTH];
	logic [7:0] value_mem [DEPTH];

	logic [7:0] fn_rd_q;
	logic [7:0] name_rd_q;
	logic [7:0] value_rd_q;
	logic [1:0] sel_q;
	logic       ok_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en && cmd.wr_region == upq_pkg::RG_FILE) begin
			fn_mem[fn_wr_idx] <= wr_data;
		end
		if (cmd.rd_en) begin
			fn_rd_q <= fn_mem[fn_rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en && cmd.wr_region == upq_pkg::RG_NAME) begin
			name_mem[pair_wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			name_rd_q <= name_mem[pair_rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en && cmd.wr_region == upq_pkg::RG_VALUE) begin
			value_mem[pair_wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			value_rd_q <= value_mem[pair_rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= upq_pkg::RG_FILE;
			ok_q  <= 1'b0;
		end else if (cmd.rd_en) begin
			sel_q <= cmd.rd_region;
			ok_q  <= cmd.rd_ok;
		end
	end

	always_comb begin
		rd_data = 8'h00;
		if (ok_q) begin
			case (sel_q)
				upq_pkg::RG_FILE:  rd_data = fn_rd_q;
				upq_pkg::RG_NAME:  rd_data = name_rd_q;
				upq_pkg::RG_VALUE: rd_data = value_rd_q;
				default:           rd_data = 8'h00;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/upq_ctrl.sv
`default_nettype none

module upq_ctrl #(
	parameter int FIELD_LEN = 16,
	parameter int MAX_PAIRS = 10,
	localparam int SLOT = FIELD_LEN + 1,
	localparam int DEPTH = MAX_PAIRS * SLOT,
	localparam int FW = $clog2(SLOT),
	localparam int AW = $clog2(DEPTH),
	localparam int CW = (FW > 3) ? FW : 3,
	localparam int PW = $clog2(MAX_PAIRS + 1)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                fire,
	input  wire logic [1:0]          opcode,
	input  wire logic [7:0]          char_in,
	input  wire logic [1:0]          read_region,
	input  wire logic [3:0]          read_element,
	input  wire logic [4:0]          read_position,
	output upq_pkg::store_cmd_t      cmd,
	output logic [FW-1:0]            fn_wr_idx,
	output logic [AW-1:0]            pair_wr_addr,
	output logic [7:0]               wr_data,
	output logic [FW-1:0]            fn_rd_idx,
	output logic [AW-1:0]            pair_rd_addr,
	output logic [2:0]               status_d,
	output logic [3:0]               pair_count_d,
	output logic [1:0]               phase_d
);

	logic [1:0]    phase_q, phase_n;
	logic [CW-1:0] cp_q, cp_n;
	logic [PW-1:0] pi_q, pi_n;
	logic          wr_req;
	logic [1:0]    wr_region;
	logic          full_pairs;
	logic          cp_past;
	logic          cp_full;

	assign full_pairs = 32'(pi_q) >= MAX_PAIRS;
	assign cp_past    = 32'(cp_q) > FIELD_LEN;
	assign cp_full    = 32'(cp_q) >= FIELD_LEN;

	always_comb begin
		status_d  = upq_pkg::ST_OK;
		phase_n   = phase_q;
		cp_n      = cp_q;
		pi_n      = pi_q;
		wr_req    = 1'b0;
		wr_region = upq_pkg::RG_FILE;
		wr_data   = upq_pkg::CH_NUL;
		if (opcode == upq_pkg::OP_FEED && char_in >= upq_pkg::CH_LOW &&
				char_in <= upq_pkg::CH_HIGH) begin
			case (phase_q)
				upq_pkg::PH_PREFIX: begin
					if (32'(cp_q) >= upq_pkg::PREFIX_LEN ||
							char_in != upq_pkg::prefix_char(cp_q[2:0])) begin
						status_d = upq_pkg::ST_BAD;
					end else if (32'(cp_q) == upq_pkg::PREFIX_LEN - 1) begin
						cp_n    = '0;
						phase_n = upq_pkg::PH_FILE;
					end else begin
						cp_n = cp_q + CW'(1);
					end
				end
				upq_pkg::PH_FILE: begin
					wr_region = upq_pkg::RG_FILE;
					if (cp_past) begin
						status_d = upq_pkg::ST_OVF;
					end else if (char_in == upq_pkg::CH_SPACE) begin
						wr_req   = 1'b1;
						status_d = upq_pkg::ST_FIN;
					end else if (char_in == upq_pkg::CH_QUEST) begin
						wr_req  = 1'b1;
						cp_n    = '0;
						phase_n = upq_pkg::PH_NAME;
					end else if (cp_full) begin
						status_d = upq_pkg::ST_OVF;
					end else if (upq_pkg::is_alnum_dot(char_in)) begin
						wr_req  = 1'b1;
						wr_data = char_in;
						cp_n    = cp_q + CW'(1);
					end else begin
						status_d = upq_pkg::ST_WRONG;
					end
				end
				upq_pkg::PH_NAME: begin
					wr_region = upq_pkg::RG_NAME;
					if (full_pairs || cp_past) begin
						status_d = upq_pkg::ST_OVF;
					end else if (char_in == upq_pkg::CH_EQ) begin
						wr_req  = 1'b1;
						cp_n    = '0;
						phase_n = upq_pkg::PH_VALUE;
					end else if (cp_full) begin
						status_d = upq_pkg::ST_OVF;
					end else if (upq_pkg::is_alnum_dot(char_in) ||
							char_in == upq_pkg::CH_UNDER) begin
						wr_req  = 1'b1;
						wr_data = char_in;
						cp_n    = cp_q + CW'(1);
					end else begin
						status_d = upq_pkg::ST_WRONG;
					end
				end
				default: begin
					wr_region = upq_pkg::RG_VALUE;
					if (full_pairs || cp_past) begin
						status_d = upq_pkg::ST_OVF;
					end else if (char_in == upq_pkg::CH_SPACE) begin
						wr_req   = 1'b1;
						pi_n     = pi_q + PW'(1);
						status_d = upq_pkg::ST_FIN;
					end else if (char_in == upq_pkg::CH_AMP) begin
						wr_req  = 1'b1;
						cp_n    = '0;
						pi_n    = pi_q + PW'(1);
						phase_n = upq_pkg::PH_NAME;
					end else if (cp_full) begin
						status_d = upq_pkg::ST_OVF;
					end else if (upq_pkg::is_alnum_dot(char_in) ||
							char_in == upq_pkg::CH_DASH) begin
						wr_req  = 1'b1;
						wr_data = char_in;
						cp_n    = cp_q + CW'(1);
					end else if (char_in == upq_pkg::CH_PLUS) begin
						wr_req  = 1'b1;
						wr_data = upq_pkg::CH_SPACE;
						cp_n    = cp_q + CW'(1);
					end else begin
						status_d = upq_pkg::ST_WRONG;
					end
				end
			endcase
		end else if (opcode == upq_pkg::OP_START) begin
			phase_n = upq_pkg::PH_PREFIX;
			cp_n    = '0;
			pi_n    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= upq_pkg::PH_PREFIX;
			cp_q    <= '0;
			pi_q    <= '0;
		end else if (fire) begin
			phase_q <= phase_n;
			cp_q    <= cp_n;
			pi_q    <= pi_n;
		end
	end

	assign fn_wr_idx    = FW'(cp_q);
	assign pair_wr_addr = AW'(32'(pi_q) * SLOT + 32'(cp_q));
	assign fn_rd_idx    = FW'(read_position);
	assign pair_rd_addr = AW'(32'(read_element) * SLOT + 32'(read_position));

	always_comb begin
		cmd.wr_en     = fire && wr_req;
		cmd.wr_region = wr_region;
		cmd.rd_en     = fire;
		cmd.rd_region = read_region;
		cmd.rd_ok     = opcode == upq_pkg::OP_READ && 32'(read_position) <= FIELD_LEN &&
			(read_region == upq_pkg::RG_FILE ||
			((read_region == upq_pkg::RG_NAME || read_region == upq_pkg::RG_VALUE) &&
			32'(read_element) < MAX_PAIRS));
	end

	assign pair_count_d = 4'(pi_n);
	assign phase_d      = phase_n;

endmodule

`default_nettype wire

// File: rtl/core/http_get_url_query_parser.sv
`default_nettype none

// channel  | valid        | ready        | word
// item     | item_valid   | item_ready   | opcode, char_in, read_region, read_element,
//          |              |              | read_position
// result   | result_valid | result_ready | status, pair_count, parse_phase, read_data
//
// One word per cycle while result_ready stays high; each result appears the cycle after its item is taken.
// Parse state sits in flops; the filename, name and value stores are memories
// with a registered read port, captured at the accept edge.
// No clearing pass: the stores are undefined until written.
// item_ready drops only while a result waits on result_ready.

module http_get_url_query_parser #(
	parameter int FIELD_LEN = 16,
	parameter int MAX_PAIRS = 10
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	output logic            item_ready,
	input  wire logic [1:0] opcode,
	input  wire logic [7:0] char_in,
	input  wire logic [1:0] read_region,
	input  wire logic [3:0] read_element,
	input  wire logic [4:0] read_position,
	output logic            result_valid,
	input  wire logic       result_ready,
	output logic [2:0]      status,
	output logic [3:0]      pair_count,
	output logic [1:0]      parse_phase,
	output logic [7:0]      read_data
);

	localparam int SLOT = FIELD_LEN + 1;
	localparam int FW = $clog2(SLOT);
	localparam int AW = $clog2(MAX_PAIRS * SLOT);

	upq_pkg::store_cmd_t cmd;
	logic          fire;
	logic [FW-1:0] fn_wr_idx;
	logic [AW-1:0] pair_wr_addr;
	logic [7:0]    wr_data;
	logic [FW-1:0] fn_rd_idx;
	logic [AW-1:0] pair_rd_addr;
	logic [2:0]    status_d;
	logic [3:0]    pair_count_d;
	logic [1:0]    phase_d;

	logic          valid_s1;
	logic          op_read_s1;
	logic [2:0]    status_s1;
	logic [3:0]    pair_count_s1;
	logic [1:0]    phase_s1;

	assign item_ready = !valid_s1 || result_ready;
	assign fire       = item_valid && item_ready;

	upq_ctrl #(
		.FIELD_LEN(FIELD_LEN),
		.MAX_PAIRS(MAX_PAIRS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.opcode       (opcode),
		.char_in      (char_in),
		.read_region  (read_region),
		.read_element (read_element),
		.read_position(read_position),
		.cmd          (cmd),
		.fn_wr_idx    (fn_wr_idx),
		.pair_wr_addr (pair_wr_addr),
		.wr_data      (wr_data),
		.fn_rd_idx    (fn_rd_idx),
		.pair_rd_addr (pair_rd_addr),
		.status_d     (status_d),
		.pair_count_d (pair_count_d),
		.phase_d      (phase_d)
	);

	upq_store #(
		.FIELD_LEN(FIELD_LEN),
		.MAX_PAIRS(MAX_PAIRS)
	) u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.fn_wr_idx   (fn_wr_idx),
		.pair_wr_addr(pair_wr_addr),
		.wr_data     (wr_data),
		.fn_rd_idx   (fn_rd_idx),
		.pair_rd_addr(pair_rd_addr),
		.rd_data     (read_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			op_read_s1    <= opcode == upq_pkg::OP_READ;
			status_s1     <= status_d;
			pair_count_s1 <= pair_count_d;
			phase_s1      <= phase_d;
		end
	end

	assign result_valid = valid_s1;
	assign status       = status_s1;
	assign pair_count   = pair_count_s1;
	assign parse_phase  = phase_s1;

	a_valid_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_valid && item_ready))
		else $error("result appeared without an accepted word");

	a_data_only_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !op_read_s1 |-> read_data == 8'h00)
		else $error("read_data nonzero for a non-read word");

	a_prefix_no_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && parse_phase == upq_pkg::PH_PREFIX |->
		pair_count == 4'd0 && status != upq_pkg::ST_FIN)
		else $error("prefix phase with pairs or finish");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import upq_pkg::*;

	localparam int FLEN = 16;
	localparam int NPAIRS = 10;
	localparam int SLOT = FLEN + 1;
	localparam logic [1:0] OP_IDLE = 2'd3;
	localparam logic [1:0] RG_NONE = 2'd3;
	localparam logic [39:0] REQ_HEAD = "GET /";
	localparam int RANDOM_WORDS = 550;
	localparam int LIMIT = 200000;

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] pairs;
		logic [1:0] phase;
		logic [7:0] data;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	logic [1:0] opcode = OP_IDLE;
	logic [7:0] char_in = 8'h00;
	logic [1:0] read_region = RG_FILE;
	logic [3:0] read_element = 4'd0;
	logic [4:0] read_position = 5'd0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic [2:0] status;
	logic [3:0] pair_count;
	logic [1:0] parse_phase;
	logic [7:0] read_data;

	// parser state as the block should hold it
	logic [1:0] ph = PH_PREFIX;
	int unsigned cpos = 0;
	int unsigned pidx = 0;
	logic [7:0] file_mem [SLOT];
	bit file_set [SLOT];
	logic [7:0] name_mem [NPAIRS * SLOT];
	bit name_set [NPAIRS * SLOT];
	logic [7:0] value_mem [NPAIRS * SLOT];
	bit value_set [NPAIRS * SLOT];

	reply_t reply_q [$];
	int errs = 0;
	int words_sent = 0;
	int burst_left = 0;
	int cyc = 0;

	http_get_url_query_parser #(.FIELD_LEN(FLEN), .MAX_PAIRS(NPAIRS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.opcode(opcode),
		.char_in(char_in),
		.read_region(read_region),
		.read_element(read_element),
		.read_position(read_position),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.status(status),
		.pair_count(pair_count),
		.parse_phase(parse_phase),
		.read_data(read_data)
	);

	always #5 clk = ~clk;

	function automatic bit in_class(logic [7:0] c, logic [7:0] extra_a, logic [7:0] extra_b);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
			c == CH_DOT || c == extra_a || c == extra_b;
	endfunction

	function automatic void keep(logic [1:0] rg, int unsigned at, logic [7:0] b);
		case (rg)
			RG_FILE: begin
				file_mem[at] = b;
				file_set[at] = 1'b1;
			end
			RG_NAME: begin
				name_mem[at] = b;
				name_set[at] = 1'b1;
			end
			default: begin
				value_mem[at] = b;
				value_set[at] = 1'b1;
			end
		endcase
	endfunction

	function automatic logic [7:0] stored_byte(logic [1:0] rg, logic [3:0] el, logic [4:0] pos);
		if (pos > FLEN)
			return CH_NUL;
		if (rg == RG_FILE)
			return file_mem[pos];
		if (el >= NPAIRS)
			return CH_NUL;
		if (rg == RG_NAME)
			return name_mem[el * SLOT + pos];
		if (rg == RG_VALUE)
			return value_mem[el * SLOT + pos];
		return CH_NUL;
	endfunction

	function automatic bit read_is_known(logic [1:0] rg, logic [3:0] el, logic [4:0] pos);
		if (pos > FLEN)
			return 1'b1;
		if (rg == RG_FILE)
			return file_set[pos];
		if (el >= NPAIRS)
			return 1'b1;
		if (rg == RG_NAME)
			return name_set[el * SLOT + pos];
		if (rg == RG_VALUE)
			return value_set[el * SLOT + pos];
		return 1'b1;
	endfunction

	function automatic reply_t parse_step(logic [1:0] op, logic [7:0] c, logic [1:0] rg,
			logic [3:0] el, logic [4:0] pos);
		reply_t r;
		int unsigned at;
		r = '0;
		r.status = ST_OK;
		at = pidx * SLOT + cpos;
		if (op == OP_START) begin
			ph = PH_PREFIX;
			cpos = 0;
			pidx = 0;
		end else if (op == OP_READ) begin
			r.data = stored_byte(rg, el, pos);
		end else if (op == OP_FEED && c >= CH_LOW && c <= CH_HIGH) begin
			case (ph)
				PH_PREFIX: begin
					if (cpos >= PREFIX_LEN || c != REQ_HEAD[8 * (4 - cpos) +: 8])
						r.status = ST_BAD;
					else if (cpos == PREFIX_LEN - 1) begin
						cpos = 0;
						ph = PH_FILE;
					end else
						cpos++;
				end
				PH_FILE: begin
					if (cpos > FLEN)
						r.status = ST_OVF;
					else if (c == CH_SPACE) begin
						keep(RG_FILE, cpos, CH_NUL);
						r.status = ST_FIN;
					end else if (c == CH_QUEST) begin
						keep(RG_FILE, cpos, CH_NUL);
						cpos = 0;
						ph = PH_NAME;
					end else if (cpos >= FLEN)
						r.status = ST_OVF;
					else if (in_class(c, CH_DOT, CH_DOT)) begin
						keep(RG_FILE, cpos, c);
						cpos++;
					end else
						r.status = ST_WRONG;
				end
				PH_NAME: begin
					if (pidx >= NPAIRS || cpos > FLEN)
						r.status = ST_OVF;
					else if (c == CH_EQ) begin
						keep(RG_NAME, at, CH_NUL);
						cpos = 0;
						ph = PH_VALUE;
					end else if (cpos >= FLEN)
						r.status = ST_OVF;
					else if (in_class(c, CH_UNDER, CH_DOT)) begin
						keep(RG_NAME, at, c);
						cpos++;
					end else
						r.status = ST_WRONG;
				end
				default: begin
					if (pidx >= NPAIRS || cpos > FLEN)
						r.status = ST_OVF;
					else if (c == CH_SPACE) begin
						keep(RG_VALUE, at, CH_NUL);
						pidx++;
						r.status = ST_FIN;
					end else if (c == CH_AMP) begin
						keep(RG_VALUE, at, CH_NUL);
						cpos = 0;
						pidx++;
						ph = PH_NAME;
					end else if (cpos >= FLEN)
						r.status = ST_OVF;
					else if (in_class(c, CH_DASH, CH_PLUS)) begin
						keep(RG_VALUE, at, (c == CH_PLUS) ? CH_SPACE : c);
						cpos++;
					end else
						r.status = ST_WRONG;
				end
			endcase
		end
		r.pairs = pidx[3:0];
		r.phase = ph;
		return r;
	endfunction

	function automatic logic [7:0] field_char(logic [1:0] rg);
		int r;
		r = $urandom_range(0, 64);
		if (r < 10)
			return 8'(r + 8'h30);
		if (r < 36)
			return 8'(r + 8'h41 - 10);
		if (r < 62)
			return 8'(r + 8'h61 - 36);
		if (r == 62 || rg == RG_FILE)
			return CH_DOT;
		if (rg == RG_NAME)
			return CH_UNDER;
		return (r == 63) ? CH_DASH : CH_PLUS;
	endfunction

	task automatic report(input string what);
		errs++;
		if (errs <= 10)
			$display("%0t: %s", $time, what);
	endtask

	// one word on the input channel, bursts with random gaps between them
	task automatic send_word(input logic [1:0] op, input logic [7:0] c, input logic [1:0] rg,
			input logic [3:0] el, input logic [4:0] pos);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150) :
				$urandom_range(1, 8);
			gap = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 20 : 3);
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		burst_left--;
		reply_q.push_back(parse_step(op, c, rg, el, pos));
		words_sent++;
		item_valid <= 1'b1;
		opcode <= op;
		char_in <= c;
		read_region <= rg;
		read_element <= el;
		read_position <= pos;
		do @(posedge clk); while (!item_ready);
	endtask

	task automatic feed_byte(input logic [7:0] c);
		send_word(OP_FEED, c, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
			5'($urandom_range(0, 31)));
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			feed_byte(s[i]);
	endtask

	task automatic read_store(input logic [1:0] rg, input logic [3:0] el, input logic [4:0] pos);
		send_word(OP_READ, 8'($urandom_range(0, 255)), rg, el, pos);
	endtask

	// random read that never touches a store entry not yet written
	task automatic read_any();
		logic [1:0] rg;
		logic [3:0] el;
		logic [4:0] pos;
		int tries;
		for (tries = 0; tries < 12; tries++) begin
			rg = 2'($urandom_range(0, 3));
			el = 4'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) :
				$urandom_range(0, (pidx < NPAIRS) ? pidx : NPAIRS - 1));
			pos = 5'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) :
				$urandom_range(0, FLEN));
			if (read_is_known(rg, el, pos))
				break;
		end
		if (!read_is_known(rg, el, pos))
			pos = 5'($urandom_range(FLEN + 1, 31));
		read_store(rg, el, pos);
	endtask

	task automatic stray(input bit noisy);
		if (noisy && $urandom_range(0, 13) == 0)
			feed_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic run_request(input int fn_len, input int n_pairs, input int field_max,
			input int tail, input bit noisy);
		int i, k, len;
		send_word(OP_START, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
			4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)));
		for (i = 0; i < PREFIX_LEN; i++) begin
			stray(noisy);
			feed_byte(REQ_HEAD[8 * (4 - i) +: 8]);
		end
		for (i = 0; i < fn_len; i++) begin
			stray(noisy);
			feed_byte(field_char(RG_FILE));
		end
		feed_byte((n_pairs == 0 && $urandom_range(0, 3) != 0) ? CH_SPACE : CH_QUEST);
		for (k = 0; k < n_pairs; k++) begin
			len = $urandom_range(1, field_max);
			for (i = 0; i < len; i++) begin
				stray(noisy);
				feed_byte(field_char(RG_NAME));
			end
			feed_byte(CH_EQ);
			len = $urandom_range(0, field_max);
			for (i = 0; i < len; i++) begin
				stray(noisy);
				feed_byte(field_char(RG_VALUE));
			end
			feed_byte((k == n_pairs - 1) ? CH_SPACE : CH_AMP);
		end
		for (i = 0; i < tail; i++)
			feed_byte($urandom_range(0, 1) ? field_char(RG_VALUE) :
				8'($urandom_range(0, 255)));
		repeat ($urandom_range(1, 5)) read_any();
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		@(posedge clk);
		while (reply_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_idle_words();
		send_word(OP_IDLE, 8'hff, RG_NONE, 4'hf, 5'h1f);
		feed_byte(8'h00);
		feed_byte(8'h1f);
		feed_byte(8'h7f);
		feed_byte(8'hff);
		read_store(RG_NONE, 4'd0, 5'd0);
		read_store(RG_NAME, 4'd15, 5'd0);
		read_store(RG_FILE, 4'd0, 5'd31);
		read_store(RG_VALUE, 4'd9, 5'd17);
	endtask

	task automatic test_prefix();
		send_text("gGET / ");
	endtask

	task automatic test_fields();
		send_text("Z#?_=+-&9= a");
		read_store(RG_FILE, 4'd0, 5'd0);
		read_store(RG_FILE, 4'd0, 5'd1);
		read_store(RG_VALUE, 4'd0, 5'd0);
		read_store(RG_NAME, 4'd1, 5'd0);
		read_store(RG_VALUE, 4'd2, 5'd0);
	endtask

	// filename one byte past full with every pair slot used, then one pair too many
	task automatic test_limits();
		run_request(FLEN + 1, NPAIRS, 2, 3, 1'b0);
		run_request(FLEN, NPAIRS + 1, FLEN + 1, 0, 1'b0);
		wait_drained();
	endtask

	task automatic test_random();
		int goal;
		logic [1:0] op;
		goal = words_sent + RANDOM_WORDS;
		while (words_sent < goal) begin
			case ($urandom_range(0, 7))
				0: repeat ($urandom_range(2, 10)) begin
					op = 2'($urandom_range(0, 3));
					if (op == OP_READ)
						read_any();
					else
						send_word(op, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
							4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)));
				end
				1: run_request($urandom_range(0, FLEN + 2), $urandom_range(0, NPAIRS + 1), FLEN + 1,
					$urandom_range(0, 4), 1'b1);
				default: run_request($urandom_range(0, 6), $urandom_range(0, 4), 4,
					($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0, 1'b1);
			endcase
			if ($urandom_range(0, 9) == 0)
				wait_drained();
		end
	endtask

	// receiver: always ready, mostly ready, mostly stalled, fixed duty pattern
	always @(posedge clk) begin
		reply_t want;
		case (cyc[10:9])
			2'd0: result_ready <= 1'b1;
			2'd1: result_ready <= ($urandom_range(0, 3) != 0);
			2'd2: result_ready <= ($urandom_range(0, 3) == 0);
			default: result_ready <= (cyc[2:0] < 3'd5);
		endcase
		if (result_valid && result_ready) begin
			if (reply_q.size() == 0)
				report("result word with nothing pending");
			else begin
				want = reply_q.pop_front();
				if ({status, pair_count, parse_phase, read_data} !== want)
					report($sformatf({"wrong result: want st %0d pairs %0d phase %0d data %02h,",
						" got st %0d pairs %0d phase %0d data %02h"},
						want.status, want.pairs, want.phase, want.data,
						status, pair_count, parse_phase, read_data));
			end
		end
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc == LIMIT) begin
			$display("http_get_url_query_parser: mismatch");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_words();
		test_prefix();
		test_fields();
		test_limits();
		test_random();
		wait_drained();
		repeat (10) @(posedge clk);
		if (errs == 0)
			$display("http_get_url_query_parser: match");
		else
			$display("http_get_url_query_parser: mismatch");
		$finish;
	end

endmodule
